/* design/sawlc_pkg.sv */
// ----------------------------------------------------------------------------
// sawlc_pkg
// shared constants for the set-associative write-back lru cache
// ----------------------------------------------------------------------------
`default_nettype none
package sawlc_pkg;
  localparam int ADDR_BITS_DEF     = 16;
  localparam int LINE_OFS_BITS_DEF = 4;
  localparam int SET_BITS_DEF      = 4;
  localparam int WAYS_DEF          = 4;

  localparam int STAMP_W = 32;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_FLUSH = 2'd2;
  localparam logic [1:0] CMD_LOAD  = 2'd3;
endpackage
`default_nettype wire

/* design/sawlc_ram.sv */
// ----------------------------------------------------------------------------
// sawlc_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none
module sawlc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr,
  output      logic [WIDTH-1:0]                 rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* design/set_assoc_writeback_lru_cache.sv */
// ----------------------------------------------------------------------------
// set_assoc_writeback_lru_cache
// byte-addressed set-associative write-back cache with lru replacement
// ----------------------------------------------------------------------------
// channel   direction  beat marker          payload
// command   in         start & !busy        command, address, write_data
// result    out        done (one cycle)     hit, read_data, lines_written_back
//
// after reset the backing memory is swept to zero, one byte a cycle, so busy
// stays high until the sweep is done, and only then is the first command taken.
// a read or write checks each way in turn, a request and a check state per way
// on the tag/stamp ram port; a write hit strobes its result sooner than a read
// hit, which adds a read-data state; busy drops in the cycle after the strobe.
// a miss first writes a dirty victim back, then fills the line, both byte by
// byte through the single byte-wide backing memory port.
// a flush walks every line, writing back each dirty one, then strobes its
// result.
// a direct load writes the backing memory in S_LOAD, then strobes its result.
// results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none
module set_assoc_writeback_lru_cache #(
  parameter int ADDR_BITS     = sawlc_pkg::ADDR_BITS_DEF,
  parameter int LINE_OFS_BITS = sawlc_pkg::LINE_OFS_BITS_DEF,
  parameter int SET_BITS      = sawlc_pkg::SET_BITS_DEF,
  parameter int WAYS          = sawlc_pkg::WAYS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic [1:0]  command,
  input  wire logic [15:0] address,
  input  wire logic [7:0]  write_data,
  output      logic        done,
  output      logic        hit,
  output      logic [7:0]  read_data,
  output      logic [6:0]  lines_written_back
);
  localparam int LINE_LEN  = 1 << LINE_OFS_BITS;
  localparam int NUM_SETS  = 1 << SET_BITS;
  localparam int NUM_LINES = NUM_SETS * WAYS;
  localparam int TAG_SHIFT = SET_BITS + LINE_OFS_BITS;
  localparam int TAG_W     = ADDR_BITS - TAG_SHIFT;
  localparam int SET_W     = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int LINE_W    = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
  localparam int DATA_D    = NUM_LINES * LINE_LEN;
  localparam int DATA_AW   = (DATA_D > 1) ? $clog2(DATA_D) : 1;
  localparam int CNT_W     = LINE_OFS_BITS + 1;
  localparam int META_W    = TAG_W + sawlc_pkg::STAMP_W;
  localparam int MEM_D     = 1 << ADDR_BITS;

  // state codes
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_MREQ  = 4'd2;
  localparam logic [3:0] S_MCHK  = 4'd3;
  localparam logic [3:0] S_DEC   = 4'd4;
  localparam logic [3:0] S_WB    = 4'd5;
  localparam logic [3:0] S_FILL  = 4'd6;
  localparam logic [3:0] S_ACC   = 4'd7;
  localparam logic [3:0] S_RDW   = 4'd8;
  localparam logic [3:0] S_FSCAN = 4'd9;
  localparam logic [3:0] S_FTAG  = 4'd10;
  localparam logic [3:0] S_LOAD  = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  logic [3:0]                  state;
  logic [ADDR_BITS-1:0]        clr_cnt;
  logic [1:0]                  cmd_q;
  logic [ADDR_BITS-1:0]        addr_q;
  logic [7:0]                  wdata_q;
  logic [SET_W-1:0]            set_q;
  logic [WAY_W-1:0]            way;
  logic [WAY_W-1:0]            hit_way;
  logic [WAY_W-1:0]            vict_way;
  logic [WAY_W-1:0]            sel_way;
  logic [TAG_W-1:0]            vict_tag;
  logic                        vict_vd;
  logic [sawlc_pkg::STAMP_W-1:0] best_stamp;
  logic [sawlc_pkg::STAMP_W-1:0] stamp_ctr;
  logic [CNT_W-1:0]            j;
  logic                        hit_q;
  logic [7:0]                  rdata_q;
  logic [6:0]                  wb_cnt;
  logic                        in_flush;
  logic [NUM_LINES-1:0]        valid_q;
  logic [NUM_LINES-1:0]        dirty_q;

  // address pieces of the current request
  logic [TAG_W-1:0]     req_tag;
  logic [DATA_AW-1:0]   req_off;
  logic [LINE_W-1:0]    line_cur;
  logic [LINE_W-1:0]    line_sel;
  logic [ADDR_BITS-1:0] wb_base;
  logic [ADDR_BITS-1:0] fill_base;
  logic [DATA_AW-1:0]   dline_base;
  logic                 last_way;
  logic                 last_set;
  logic                 j_end;

  assign req_tag    = TAG_W'(addr_q >> TAG_SHIFT);
  assign req_off    = DATA_AW'(addr_q & ADDR_BITS'(LINE_LEN - 1));
  assign line_cur   = LINE_W'(int'(set_q) * WAYS + int'(way));
  assign line_sel   = LINE_W'(int'(set_q) * WAYS + int'(sel_way));
  assign wb_base    = (ADDR_BITS'(vict_tag) << TAG_SHIFT)
                    | (ADDR_BITS'(set_q) << LINE_OFS_BITS);
  assign fill_base  = (ADDR_BITS'(req_tag) << TAG_SHIFT)
                    | (ADDR_BITS'(set_q) << LINE_OFS_BITS);
  assign dline_base = DATA_AW'(line_sel) << LINE_OFS_BITS;
  assign last_way   = (way == WAY_W'(WAYS - 1));
  assign last_set   = (set_q == SET_W'(NUM_SETS - 1));
  assign j_end      = (j == CNT_W'(LINE_LEN));

  // tag and stamp ram, one word per line
  logic                 meta_we;
  logic [META_W-1:0]    meta_wdata;
  logic [META_W-1:0]    meta_rdata;
  logic [TAG_W-1:0]     m_tag;
  logic [sawlc_pkg::STAMP_W-1:0] m_stamp;
  logic                 m_valid;

  assign meta_we    = (state == S_ACC);
  assign meta_wdata = {req_tag, stamp_ctr};
  // a line never filled reads as tag zero, stamp zero
  assign m_valid    = valid_q[line_cur];
  assign m_tag      = m_valid ? meta_rdata[META_W-1 -: TAG_W] : '0;
  assign m_stamp    = m_valid ? meta_rdata[sawlc_pkg::STAMP_W-1:0] : '0;

  sawlc_ram #(.WIDTH(META_W), .DEPTH(NUM_LINES)) u_meta (
    .clk   (clk),
    .we    (meta_we),
    .waddr (line_sel),
    .wdata (meta_wdata),
    .raddr (line_cur),
    .rdata (meta_rdata)
  );

  // line data ram
  logic               data_we;
  logic [DATA_AW-1:0] data_waddr;
  logic [7:0]         data_wdata;
  logic [DATA_AW-1:0] data_raddr;
  logic [7:0]         data_rdata;

  // backing memory
  logic                 back_we;
  logic [ADDR_BITS-1:0] back_waddr;
  logic [7:0]           back_wdata;
  logic [ADDR_BITS-1:0] back_raddr;
  logic [7:0]           back_rdata;

  always_comb begin
    data_we    = 1'b0;
    data_waddr = dline_base | DATA_AW'(j - CNT_W'(1));
    data_wdata = back_rdata;
    data_raddr = dline_base | DATA_AW'(j);
    back_we    = 1'b0;
    back_waddr = wb_base | ADDR_BITS'(j - CNT_W'(1));
    back_wdata = data_rdata;
    back_raddr = fill_base | ADDR_BITS'(j);
    unique case (state)
      S_CLEAR: begin
        back_we    = 1'b1;
        back_waddr = clr_cnt;
        back_wdata = '0;
      end
      S_LOAD: begin
        back_we    = 1'b1;
        back_waddr = addr_q;
        back_wdata = wdata_q;
      end
      // read data byte j, write byte j-1 out in the cycle after its read
      S_WB: begin
        back_we = (j != '0);
      end
      // read backing byte j, write byte j-1 into the line
      S_FILL: begin
        data_we = (j != '0);
      end
      S_ACC: begin
        data_raddr = dline_base | req_off;
        data_waddr = dline_base | req_off;
        data_wdata = wdata_q;
        data_we    = (cmd_q == sawlc_pkg::CMD_WRITE);
      end
      default: begin
      end
    endcase
  end

  sawlc_ram #(.WIDTH(8), .DEPTH(DATA_D)) u_data (
    .clk   (clk),
    .we    (data_we),
    .waddr (data_waddr),
    .wdata (data_wdata),
    .raddr (data_raddr),
    .rdata (data_rdata)
  );

  sawlc_ram #(.WIDTH(8), .DEPTH(MEM_D)) u_back (
    .clk   (clk),
    .we    (back_we),
    .waddr (back_waddr),
    .wdata (back_wdata),
    .raddr (back_raddr),
    .rdata (back_rdata)
  );

  assign busy               = (state != S_IDLE);
  assign done               = (state == S_DONE);
  assign hit                = hit_q;
  assign read_data          = rdata_q;
  assign lines_written_back = wb_cnt;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      valid_q   <= '0;
      dirty_q   <= '0;
      stamp_ctr <= sawlc_pkg::STAMP_W'(1);
      hit_q     <= 1'b0;
      rdata_q   <= '0;
      wb_cnt    <= '0;
      in_flush  <= 1'b0;
      way       <= '0;
      set_q     <= '0;
      j         <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            cmd_q    <= command;
            addr_q   <= ADDR_BITS'(address);
            wdata_q  <= write_data;
            // a flush walks from set zero
            set_q    <= (command == sawlc_pkg::CMD_FLUSH) ? '0 :
                        SET_W'((ADDR_BITS'(address) >> LINE_OFS_BITS)
                               & ADDR_BITS'(NUM_SETS - 1));
            way      <= '0;
            hit_q    <= 1'b0;
            rdata_q  <= '0;
            wb_cnt   <= '0;
            in_flush <= (command == sawlc_pkg::CMD_FLUSH);
            case (command)
              sawlc_pkg::CMD_FLUSH: state <= S_FSCAN;
              sawlc_pkg::CMD_LOAD:  state <= S_LOAD;
              default:              state <= S_MREQ;
            endcase
          end
        end
        S_MREQ: state <= S_MCHK;
        S_MCHK: begin
          if (m_valid && m_tag == req_tag && !hit_q) begin
            hit_q   <= 1'b1;
            hit_way <= way;
          end
          // oldest stamp wins, ties keep the lower way
          if (way == '0 || m_stamp < best_stamp) begin
            best_stamp <= m_stamp;
            vict_way   <= way;
            vict_tag   <= m_tag;
            vict_vd    <= m_valid && dirty_q[line_cur];
          end
          if (last_way) begin
            state <= S_DEC;
          end else begin
            way   <= way + 1'b1;
            state <= S_MREQ;
          end
        end
        S_DEC: begin
          j <= '0;
          if (hit_q) begin
            sel_way <= hit_way;
            state   <= S_ACC;
          end else begin
            sel_way <= vict_way;
            state   <= vict_vd ? S_WB : S_FILL;
          end
        end
        S_WB: begin
          if (j_end) begin
            j <= '0;
            if (in_flush) begin
              dirty_q[line_sel] <= 1'b0;
              wb_cnt            <= wb_cnt + 1'b1;
              way               <= last_way ? '0 : way + 1'b1;
              if (last_way) begin
                set_q <= set_q + 1'b1;
              end
              state <= (last_way && last_set) ? S_DONE : S_FSCAN;
            end else begin
              wb_cnt <= 7'd1;
              state  <= S_FILL;
            end
          end else begin
            j <= j + 1'b1;
          end
        end
        S_FILL: begin
          j <= j + 1'b1;
          if (j_end) begin
            valid_q[line_sel] <= 1'b1;
            dirty_q[line_sel] <= 1'b0;
            state             <= S_ACC;
          end
        end
        S_ACC: begin
          if (stamp_ctr != '1) begin
            stamp_ctr <= stamp_ctr + 1'b1;
          end
          if (cmd_q == sawlc_pkg::CMD_WRITE) begin
            dirty_q[line_sel] <= 1'b1;
            state             <= S_DONE;
          end else begin
            state <= S_RDW;
          end
        end
        S_RDW: begin
          rdata_q <= data_rdata;
          state   <= S_DONE;
        end
        S_FSCAN: begin
          if (valid_q[line_cur] && dirty_q[line_cur]) begin
            state <= S_FTAG;
          end else begin
            way <= last_way ? '0 : way + 1'b1;
            if (last_way) begin
              set_q <= set_q + 1'b1;
            end
            if (last_way && last_set) begin
              state <= S_DONE;
            end
          end
        end
        S_FTAG: begin
          vict_tag <= m_tag;
          sel_way  <= way;
          j        <= '0;
          state    <= S_WB;
        end
        S_LOAD: state <= S_DONE;
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* verif/set_assoc_writeback_lru_cache_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_writeback_lru_cache_test
// self-checking bench: directed table then random traffic over a few hot
// regions, each beat checked against a behavioural cache model kept here
// ----------------------------------------------------------------------------
module set_assoc_writeback_lru_cache_test;

  localparam int LINE_BYTES = 16;
  localparam int SET_COUNT  = 16;
  localparam int WAY_COUNT  = 4;
  localparam int LINE_COUNT = SET_COUNT * WAY_COUNT;

  typedef struct packed {
    logic       hit;
    logic [7:0] rdata;
    logic [6:0] wb;
  } outcome_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [15:0] addr;
    logic [7:0]  wdata;
    bit          typed;   // expected outcome given in the row
    outcome_t    want;
  } row_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic [1:0]  command = sawlc_pkg::CMD_READ;
  logic [15:0] address = '0;
  logic [7:0]  write_data = '0;
  logic        busy, done, hit;
  logic [7:0]  read_data;
  logic [6:0]  lines_written_back;

  set_assoc_writeback_lru_cache uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .address(address), .write_data(write_data), .done(done), .hit(hit),
    .read_data(read_data), .lines_written_back(lines_written_back)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // model of the cache contents
  logic [7:0]  mdl_tag   [LINE_COUNT];
  bit          mdl_valid [LINE_COUNT];
  bit          mdl_dirty [LINE_COUNT];
  logic [31:0] mdl_stamp [LINE_COUNT];
  logic [7:0]  mdl_line  [LINE_COUNT*LINE_BYTES];
  logic [7:0]  mdl_mem   [65536];
  logic [31:0] mdl_clock;

  outcome_t pending_outcomes[$];
  int errors = 0;
  int idle_pct = 0;

  function automatic void evict_line(int ln);
    logic [15:0] base;
    base = {mdl_tag[ln], 4'(ln / WAY_COUNT), 4'd0};
    for (int j = 0; j < LINE_BYTES; j++) mdl_mem[base + j] = mdl_line[ln*LINE_BYTES + j];
  endfunction

  function automatic outcome_t cache_access(logic [1:0] cmd, logic [15:0] addr,
                                            logic [7:0] wdata);
    outcome_t o;
    int first, ln;
    bit found;
    o = '0;
    found = 0;
    if (cmd == sawlc_pkg::CMD_FLUSH) begin
      for (int i = 0; i < LINE_COUNT; i++)
        if (mdl_valid[i] && mdl_dirty[i]) begin
          evict_line(i);
          mdl_dirty[i] = 0;
          o.wb++;
        end
    end else if (cmd == sawlc_pkg::CMD_LOAD) begin
      mdl_mem[addr] = wdata;
    end else begin
      first = addr[7:4] * WAY_COUNT;
      ln = first;
      for (int w = 0; w < WAY_COUNT; w++)
        if (!found && mdl_valid[first+w] && mdl_tag[first+w] == addr[15:8]) begin
          ln = first + w;
          found = 1;
        end
      if (!found) begin
        // oldest stamp, lowest way on ties
        for (int w = 1; w < WAY_COUNT; w++)
          if (mdl_stamp[first+w] < mdl_stamp[ln]) ln = first + w;
        if (mdl_valid[ln] && mdl_dirty[ln]) begin
          evict_line(ln);
          o.wb = 1;
        end
        for (int j = 0; j < LINE_BYTES; j++)
          mdl_line[ln*LINE_BYTES + j] = mdl_mem[{addr[15:4], 4'(j)}];
        mdl_valid[ln] = 1;
        mdl_dirty[ln] = 0;
        mdl_tag[ln] = addr[15:8];
      end
      o.hit = found;
      mdl_stamp[ln] = mdl_clock;
      if (mdl_clock != '1) mdl_clock++;
      if (cmd == sawlc_pkg::CMD_READ) begin
        o.rdata = mdl_line[ln*LINE_BYTES + addr[3:0]];
      end else begin
        mdl_line[ln*LINE_BYTES + addr[3:0]] = wdata;
        mdl_dirty[ln] = 1;
      end
    end
    return o;
  endfunction

  // drive one beat and wait until busy drops
  task automatic issue(logic [1:0] cmd, logic [15:0] addr, logic [7:0] wdata,
                       bit typed, outcome_t want);
    outcome_t o;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) @(posedge clk);
    start <= 1;
    command <= cmd;
    address <= addr;
    write_data <= wdata;
    @(posedge clk);
    while (busy) @(posedge clk);
    o = cache_access(cmd, addr, wdata);
    if (typed && o != want) begin
      $display("%0t table row disagrees with model: want %p model %p", $time, want, o);
      errors++;
    end
    pending_outcomes.push_back(typed ? want : o);
    start <= 0;
    // the block is busy in the cycle after a beat anyway
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  // result monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t unexpected beat: hit %0d data %0d wb %0d", $time, hit, read_data,
                 lines_written_back);
        errors++;
      end else begin
        outcome_t e;
        e = pending_outcomes.pop_front();
        if (hit !== e.hit) begin
          $display("%0t hit: expected %0d actual %0d", $time, e.hit, hit);
          errors++;
        end
        if (read_data !== e.rdata) begin
          $display("%0t read_data: expected %0d actual %0d", $time, e.rdata, read_data);
          errors++;
        end
        if (lines_written_back !== e.wb) begin
          $display("%0t lines_written_back: expected %0d actual %0d", $time, e.wb,
                   lines_written_back);
          errors++;
        end
      end
    end
  end

  // directed rows; outcome typed only where obvious
  row_t table_rows[] = '{
    '{sawlc_pkg::CMD_READ,  16'h0000, 8'h00, 1, '{1'b0, 8'h00, 7'd0}},  // cold miss reads zero
    '{sawlc_pkg::CMD_READ,  16'h0000, 8'h00, 1, '{1'b1, 8'h00, 7'd0}},  // now resident
    '{sawlc_pkg::CMD_FLUSH, 16'h0000, 8'h00, 1, '{1'b0, 8'h00, 7'd0}},  // nothing dirty
    '{sawlc_pkg::CMD_LOAD,  16'hFFFF, 8'hFF, 1, '{1'b0, 8'h00, 7'd0}},  // top of memory
    '{sawlc_pkg::CMD_READ,  16'hFFFF, 8'h00, 0, '{1'b0, 8'h00, 7'd0}},
    '{sawlc_pkg::CMD_WRITE, 16'hFFF0, 8'hA5, 0, '{1'b0, 8'h00, 7'd0}},
    '{sawlc_pkg::CMD_WRITE, 16'h0001, 8'hFF, 0, '{1'b0, 8'h00, 7'd0}},
    '{sawlc_pkg::CMD_LOAD,  16'h0001, 8'h5A, 0, '{1'b0, 8'h00, 7'd0}},  // stale copy
    '{sawlc_pkg::CMD_READ,  16'h0001, 8'h00, 0, '{1'b0, 8'h00, 7'd0}},
    // fill set 0 past its ways to force dirty victims
    '{sawlc_pkg::CMD_WRITE, 16'h0100, 8'h11, 0, '{1'b0, 8'h00, 7'd0}},
    '{sawlc_pkg::CMD_WRITE, 16'h0200, 8'h22, 0, '{1'b0, 8'h00, 7'd0}},
    '{sawlc_pkg::CMD_WRITE, 16'h0300, 8'h33, 0, '{1'b0, 8'h00, 7'd0}},
    '{sawlc_pkg::CMD_WRITE, 16'h0400, 8'h44, 0, '{1'b0, 8'h00, 7'd0}},
    '{sawlc_pkg::CMD_READ,  16'h0000, 8'h00, 0, '{1'b0, 8'h00, 7'd0}},
    '{sawlc_pkg::CMD_READ,  16'h0001, 8'h00, 0, '{1'b0, 8'h00, 7'd0}},
    '{sawlc_pkg::CMD_FLUSH, 16'hFFFF, 8'h00, 0, '{1'b0, 8'h00, 7'd0}},
    '{sawlc_pkg::CMD_READ,  16'h0100, 8'h00, 0, '{1'b0, 8'h00, 7'd0}},
    '{sawlc_pkg::CMD_FLUSH, 16'h0000, 8'h00, 1, '{1'b0, 8'h00, 7'd0}},  // already clean
    '{sawlc_pkg::CMD_READ,  16'h5555, 8'h00, 0, '{1'b0, 8'h00, 7'd0}},
    '{sawlc_pkg::CMD_WRITE, 16'hAAAA, 8'h55, 0, '{1'b0, 8'h00, 7'd0}}
  };

  initial begin
    logic [15:0] a;
    logic [1:0]  c;
    int pick;
    for (int i = 0; i < LINE_COUNT; i++) begin
      mdl_tag[i] = 0; mdl_valid[i] = 0; mdl_dirty[i] = 0; mdl_stamp[i] = 0;
    end
    foreach (mdl_line[i]) mdl_line[i] = 0;
    foreach (mdl_mem[i]) mdl_mem[i] = 0;
    mdl_clock = 1;
    repeat (3) @(posedge clk);
    rst <= 0;

    foreach (table_rows[i])
      issue(table_rows[i].cmd, table_rows[i].addr, table_rows[i].wdata,
            table_rows[i].typed, table_rows[i].want);

    // random phases: none, sender idle, receiver note n/a, mixed
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 65 : (ph == 3) ? 10 : 0;
      for (int n = 0; n < 270; n++) begin
        pick = $urandom_range(99);
        // mostly a few tags per set so hits and evictions both happen
        if (pick < 80) a = {5'd0, 3'($urandom_range(5)), 4'($urandom), 4'($urandom)};
        else a = 16'($urandom);
        if (n % 8 == 0 && pick >= 80) a = {3'($urandom), 5'($urandom), a[7:0]};
        pick = $urandom_range(99);
        c = (pick < 40) ? sawlc_pkg::CMD_READ :
            (pick < 80) ? sawlc_pkg::CMD_WRITE :
            (pick < 88) ? sawlc_pkg::CMD_FLUSH : sawlc_pkg::CMD_LOAD;
        issue(c, a, 8'($urandom), 0, '0);
      end
      drain();  // sender holds off until all results are back
    end

    drain();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
